@@ src/rkr_pkg.sv @@
package rkr_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 24;

    localparam int STEP_BITS = 25;
    localparam int MU_BITS   = 29;
    localparam int A_BITS    = 30;
    localparam int CFG_BITS  = 30;
    localparam int IDX_BITS  = 2;

    localparam logic [IDX_BITS-1:0] REG_STEP = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_MU   = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_A    = 2'd2;

    localparam logic [STEP_BITS-1:0] STEP_RST = 25'd167772;
    localparam logic [MU_BITS-1:0]   MU_RST   = 29'd16777216;
    localparam logic [A_BITS-1:0]    A_RST    = 30'd83886080;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
    } rkr_in_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               overflow;
    } rkr_out_t;

    typedef struct packed {
        logic [STEP_BITS-1:0]     step_size;
        logic [MU_BITS-1:0]       mu_coef;
        logic signed [A_BITS-1:0] a_coef;
    } rkr_cfg_t;

endpackage

@@ src/rkr_mul.sv @@
// saturating fixed-point product, rounded toward minus infinity
module rkr_mul #(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic signed [W-1:0] p,
    output logic                sat
);
    logic signed [2*W-1:0] full;
    logic signed [2*W-F-1:0] q;
    localparam logic signed [2*W-F-1:0] QMAX = (2*W-F)'((64'sd1 <<< (W-1)) - 1);
    localparam logic signed [2*W-F-1:0] QMIN = -QMAX - (2*W-F)'(1);

    always_comb begin
        full = a * b;
        q    = full[2*W-1:F];
        sat  = 1'b0;
        if (q > QMAX) begin
            p = {1'b0, {(W-1){1'b1}}};
            sat = 1'b1;
        end else if (q < QMIN) begin
            p = {1'b1, {(W-1){1'b0}}};
            sat = 1'b1;
        end else begin
            p = q[W-1:0];
        end
    end
endmodule

@@ src/rkr_stage.sv @@
// one derivative evaluation plus the trial point for the next stage
// half: 1 -> t = s + h*k/2, 0 -> t = s + h*k
// last: sum gains k once and the trial point raises no flags
module rkr_stage
    import rkr_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                v_i,
    input  logic                half,
    input  logic signed [W-1:0] h,
    input  logic signed [W-1:0] mu,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] s_i [3],
    input  logic signed [W-1:0] t_i [3],
    input  logic signed [W-1:0] acc_i [3],
    input  logic                ov_i,
    input  logic                first,
    input  logic                last,
    output logic                v_o,
    output logic signed [W-1:0] s_o [3],
    output logic signed [W-1:0] t_o [3],
    output logic signed [W-1:0] acc_o [3],
    output logic                ov_o
);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] clip(input logic signed [W+1:0] v,
                                                 output logic o);
        o = 1'b0;
        if (v > (W+2)'(WMAX)) begin
            o = 1'b1;
            return WMAX;
        end
        if (v < (W+2)'(WMIN)) begin
            o = 1'b1;
            return WMIN;
        end
        return v[W-1:0];
    endfunction

    // cycle A: differences and products
    logic signed [W-1:0] zma;
    logic                zma_o;
    logic signed [W-1:0] p_yz, p_mx, p_xz, p_my, p_xy;
    logic [4:0]          ps;
    logic signed [W-1:0] one;
    logic                one_o;

    always_comb begin
        zma = clip((W+2)'(t_i[2]) - (W+2)'(a), zma_o);
        one = clip((W+2)'(64'sd1 <<< F), one_o);
    end

    rkr_mul #(.W(W), .F(F)) u_m0 (.a(t_i[1]), .b(t_i[2]), .p(p_yz), .sat(ps[0]));
    rkr_mul #(.W(W), .F(F)) u_m1 (.a(mu), .b(t_i[0]), .p(p_mx), .sat(ps[1]));
    rkr_mul #(.W(W), .F(F)) u_m2 (.a(t_i[0]), .b(zma), .p(p_xz), .sat(ps[2]));
    rkr_mul #(.W(W), .F(F)) u_m3 (.a(mu), .b(t_i[1]), .p(p_my), .sat(ps[3]));
    rkr_mul #(.W(W), .F(F)) u_m4 (.a(t_i[0]), .b(t_i[1]), .p(p_xy), .sat(ps[4]));

    logic                va_reg;
    logic signed [W-1:0] pa_reg [5];
    logic signed [W-1:0] sa_reg [3];
    logic signed [W-1:0] aa_reg [3];
    logic signed [W-1:0] onea_reg;
    logic                oa_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= v_i;
        end
        if (en) begin
            pa_reg   <= '{p_yz, p_mx, p_xz, p_my, p_xy};
            sa_reg   <= s_i;
            aa_reg   <= acc_i;
            onea_reg <= one;
            oa_reg   <= ov_i | (|ps) | zma_o | one_o;
        end
    end

    // cycle B: derivative k, h*k
    logic signed [W-1:0] k [3];
    logic [2:0]          ko;
    logic signed [W-1:0] hk [3];
    logic [2:0]          ho;

    always_comb begin
        k[0] = clip((W+2)'(pa_reg[0]) - (W+2)'(pa_reg[1]), ko[0]);
        k[1] = clip((W+2)'(pa_reg[2]) - (W+2)'(pa_reg[3]), ko[1]);
        k[2] = clip((W+2)'(onea_reg) - (W+2)'(pa_reg[4]), ko[2]);
    end

    for (genvar i = 0; i < 3; i++) begin : g_hk
        rkr_mul #(.W(W), .F(F)) u_h (.a(h), .b(k[i]), .p(hk[i]), .sat(ho[i]));
    end

    logic                vb_reg;
    logic signed [W-1:0] kb_reg [3];
    logic signed [W-1:0] hkb_reg [3];
    logic signed [W-1:0] sb_reg [3];
    logic signed [W-1:0] ab_reg [3];
    logic                ob_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            kb_reg  <= k;
            hkb_reg <= hk;
            sb_reg  <= sa_reg;
            ab_reg  <= aa_reg;
            ob_reg  <= oa_reg | (|ko) | ((|ho) & !last);
        end
    end

    // cycle C: trial point and running weighted sum
    logic signed [W-1:0] tn [3];
    logic signed [W-1:0] an [3];
    logic [2:0]          to, ao1, ao2;
    logic signed [W-1:0] kk;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tn[i] = clip((W+2)'(sb_reg[i])
                         + (half ? ((W+2)'(hkb_reg[i]) >>> 1) : (W+2)'(hkb_reg[i])),
                         to[i]);
            kk = clip((W+2)'(kb_reg[i]) + (W+2)'(kb_reg[i]), ao1[i]);
            ao2[i] = 1'b0;
            if (first) begin
                ao1[i] = 1'b0;
                an[i]  = kb_reg[i];
            end else if (last) begin
                ao1[i] = 1'b0;
                an[i]  = clip((W+2)'(ab_reg[i]) + (W+2)'(kb_reg[i]), ao2[i]);
            end else begin
                an[i]  = clip((W+2)'(ab_reg[i]) + (W+2)'(kk), ao2[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_o <= 1'b0;
        end else if (en) begin
            v_o <= vb_reg;
        end
        if (en) begin
            s_o   <= sb_reg;
            t_o   <= tn;
            acc_o <= an;
            ov_o  <= ob_reg | ((|to) & !last) | (|ao1) | (|ao2);
        end
    end
endmodule

@@ src/rkr_final.sv @@
// fourth derivative, closing sum, h*sum/6 and result register
module rkr_final
    import rkr_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                v_i,
    input  logic signed [W-1:0] h,
    input  logic signed [W-1:0] mu,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] s_i [3],
    input  logic signed [W-1:0] t_i [3],
    input  logic signed [W-1:0] acc_i [3],
    input  logic                ov_i,
    output logic                v_o,
    output logic signed [W-1:0] r_o [3],
    output logic                ov_o
);
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] clip(input logic signed [W+1:0] v,
                                                 output logic o);
        o = 1'b0;
        if (v > (W+2)'(WMAX)) begin
            o = 1'b1;
            return WMAX;
        end
        if (v < (W+2)'(WMIN)) begin
            o = 1'b1;
            return WMIN;
        end
        return v[W-1:0];
    endfunction

    // k4 via its own stage instance in closing mode: the sum gains k4 once
    logic                v4;
    logic signed [W-1:0] s4 [3], t4 [3], a4 [3];
    logic                o4;

    rkr_stage #(.W(W), .F(F)) u_k4 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .v_i(v_i), .half(1'b0),
        .h(h), .mu(mu), .a(a), .s_i(s_i), .t_i(t_i), .acc_i(acc_i),
        .ov_i(ov_i), .first(1'b0), .last(1'b1), .v_o(v4), .s_o(s4), .t_o(t4),
        .acc_o(a4), .ov_o(o4)
    );

    // h*sum
    logic signed [W-1:0] hs [3];
    logic [2:0]          hso;

    for (genvar i = 0; i < 3; i++) begin : g_hs
        rkr_mul #(.W(W), .F(F)) u_hs (.a(h), .b(a4[i]), .p(hs[i]), .sat(hso[i]));
    end

    logic                vh_reg;
    logic signed [W-1:0] hs_reg [3];
    logic signed [W-1:0] sh_reg [3];
    logic                oh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vh_reg <= 1'b0;
        end else if (en) begin
            vh_reg <= v4;
        end
        if (en) begin
            hs_reg <= hs;
            sh_reg <= s4;
            oh_reg <= o4 | (|hso);
        end
    end

    // floor(v/6): bias v into [2^W, 2^(W+1)), halve, then divide by 3
    // with a reciprocal multiply; the bias leaves 2^(W-2) in the quotient
    localparam logic [W+1:0] BIAS  = (W+2)'(3) << (W-1);
    localparam logic [W-1:0] RECIP = W'(((128'd1 << (W+1)) + 128'd2) / 128'd3);
    localparam logic [W-1:0] QBIAS = W'(1) << (W-2);

    logic [W+1:0]        biased [3];
    logic [W-1:0]        halved [3];
    logic [2*W-1:0]      prod [3];
    logic signed [W-1:0] q6 [3];
    logic signed [W+1:0] rsum [3];
    logic signed [W-1:0] res [3];
    logic [2:0]          ro;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            biased[i] = (W+2)'(hs_reg[i]) + BIAS;
            halved[i] = biased[i][W:1];
            prod[i]   = (2*W)'(halved[i]) * (2*W)'(RECIP);
            q6[i]     = W'(prod[i][2*W-1:W+1]) - QBIAS;
            rsum[i]   = (W+2)'(sh_reg[i]) + (W+2)'(q6[i]);
            res[i]    = clip(rsum[i], ro[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_o <= 1'b0;
        end else if (en) begin
            v_o <= vh_reg;
        end
        if (en) begin
            r_o  <= res;
            ov_o <= oh_reg | (|ro);
        end
    end

    logic unused;
    assign unused = ^{t4[0], t4[1], t4[2]};
endmodule

@@ src/rk4_rikitake_step_unit.sv @@
// One RK4 step of the Rikitake dynamo per beat, signed fixed point, saturating.
// Fully pipelined: one state vector is taken every cycle while not stalled;
// the pipeline has four derivative stages of three register levels each, plus
// the h*sum product level and the divide-by-6 and add result level; it stalls
// as a whole while m_ready is low with a valid result waiting.
module rk4_rikitake_step_unit #(
    parameter int WORD_BITS = rkr_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = rkr_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [rkr_pkg::IDX_BITS-1:0] cfg_idx,
    input  logic [rkr_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rkr_pkg::rkr_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rkr_pkg::rkr_out_t           m_data
);
    import rkr_pkg::*;
    localparam int W = WORD_BITS;
    localparam int F = FRAC_BITS;

    rkr_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{STEP_RST, MU_RST, A_RST};
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_STEP: cfg_reg.step_size <= cfg_data[STEP_BITS-1:0];
                REG_MU:   cfg_reg.mu_coef   <= cfg_data[MU_BITS-1:0];
                REG_A:    cfg_reg.a_coef    <= cfg_data[A_BITS-1:0];
                default:  ;
            endcase
        end
    end

    logic signed [W-1:0] h, mu, a;
    assign h  = W'(cfg_reg.step_size);
    assign mu = W'(cfg_reg.mu_coef);
    assign a  = W'(cfg_reg.a_coef);

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [W-1:0] s0 [3];
    assign s0[0] = W'(s_data.x_in);
    assign s0[1] = W'(s_data.y_in);
    assign s0[2] = W'(s_data.z_in);

    logic                v1, v2, v3;
    logic signed [W-1:0] sa [3], ta [3], aa [3];
    logic signed [W-1:0] sb [3], tb [3], ab [3];
    logic signed [W-1:0] sc [3], tc [3], ac [3];
    logic                o1, o2, o3;

    rkr_stage #(.W(W), .F(F)) u_k1 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .v_i(s_valid && s_ready),
        .half(1'b1), .h(h), .mu(mu), .a(a), .s_i(s0), .t_i(s0), .acc_i(s0),
        .ov_i(1'b0), .first(1'b1), .last(1'b0), .v_o(v1), .s_o(sa), .t_o(ta),
        .acc_o(aa), .ov_o(o1)
    );
    rkr_stage #(.W(W), .F(F)) u_k2 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .v_i(v1), .half(1'b1),
        .h(h), .mu(mu), .a(a), .s_i(sa), .t_i(ta), .acc_i(aa), .ov_i(o1),
        .first(1'b0), .last(1'b0), .v_o(v2), .s_o(sb), .t_o(tb), .acc_o(ab),
        .ov_o(o2)
    );
    rkr_stage #(.W(W), .F(F)) u_k3 (
        .aclk(aclk), .aresetn(aresetn), .en(en), .v_i(v2), .half(1'b0),
        .h(h), .mu(mu), .a(a), .s_i(sb), .t_i(tb), .acc_i(ab), .ov_i(o2),
        .first(1'b0), .last(1'b0), .v_o(v3), .s_o(sc), .t_o(tc), .acc_o(ac),
        .ov_o(o3)
    );

    // k4 enters with weight one: pre-subtract nothing, final stage adds it once
    logic                vf;
    logic signed [W-1:0] rf [3];
    logic                of;

    rkr_final #(.W(W), .F(F)) u_fin (
        .aclk(aclk), .aresetn(aresetn), .en(en), .v_i(v3), .h(h), .mu(mu),
        .a(a), .s_i(sc), .t_i(tc), .acc_i(ac), .ov_i(o3), .v_o(vf),
        .r_o(rf), .ov_o(of)
    );

    assign m_valid        = vf;
    assign m_data.x_out   = 32'(rf[0]);
    assign m_data.y_out   = 32'(rf[1]);
    assign m_data.z_out   = 32'(rf[2]);
    assign m_data.overflow = of;
endmodule

@@ src/rkr_chk.sv @@
module rkr_chk (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input rkr_pkg::rkr_out_t m_data
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("stall without result");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready) else $error("accept during stall");
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid) else $error("input beat withdrawn");
endmodule

bind rk4_rikitake_step_unit rkr_chk u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
